[rtl/hss_pkg.sv]
// Shared types, constants and the soil palette for the hillshade pixel color core.
package hss_pkg;

    // Widths of fixed fields.
    localparam int CLASS_WIDTH = 3;
    localparam int LEVEL_WIDTH = 20;
    localparam int CHAN_WIDTH  = 8;
    localparam int LIGHT_WIDTH = 9;
    localparam int PIXEL_WIDTH = 32;

    // Light factor bounds in Q8 (0.4 and 1.3 rounded to nearest).
    localparam int LIGHT_MIN_Q8 = 102;
    localparam int LIGHT_MAX_Q8 = 333;

    // Raw light offset: 0.5 with 9 fraction bits.
    localparam int LIGHT_BIAS_Q9 = 256;

    // Opaque alpha byte.
    localparam logic [CHAN_WIDTH-1:0] ALPHA_OPAQUE = 8'd255;

    // Soil class codes.
    localparam logic [CLASS_WIDTH-1:0] SOIL_RASO         = 3'd0;
    localparam logic [CLASS_WIDTH-1:0] SOIL_BEMDES       = 3'd1;
    localparam logic [CLASS_WIDTH-1:0] SOIL_HYDROMORPHIC = 3'd2;
    localparam logic [CLASS_WIDTH-1:0] SOIL_CLAY         = 3'd3;
    localparam logic [CLASS_WIDTH-1:0] SOIL_BTEXTURAL    = 3'd4;
    localparam logic [CLASS_WIDTH-1:0] SOIL_ROCK         = 3'd5;
    localparam logic [CLASS_WIDTH-1:0] SOIL_NONE         = 3'd6;
    localparam logic [CLASS_WIDTH-1:0] SOIL_OTHER        = 3'd7;

    // One color, packed like the low three bytes of a pixel word.
    typedef struct packed {
        logic [CHAN_WIDTH-1:0] blue;
        logic [CHAN_WIDTH-1:0] green;
        logic [CHAN_WIDTH-1:0] red;
    } rgb_t;

    // Per-cell shading controls from the terrain stage to the color stage.
    typedef struct packed {
        logic                   under;
        logic [LIGHT_WIDTH-1:0] light;
    } hss_shade_ctrl_t;

    // Water blue that submerged cells are averaged with.
    localparam rgb_t WATER_RGB = '{blue: 8'd200, green: 8'd100, red: 8'd50};

    // Base color of each soil class; the catch-all class is plain gray.
    function automatic rgb_t soil_color(input logic [CLASS_WIDTH-1:0] cls);
        rgb_t c;
        unique case (cls)
            SOIL_RASO:         c = '{blue: 8'd100, green: 8'd200, red: 8'd200};
            SOIL_BEMDES:       c = '{blue: 8'd19,  green: 8'd69,  red: 8'd139};
            SOIL_HYDROMORPHIC: c = '{blue: 8'd100, green: 8'd100, red: 8'd100};
            SOIL_CLAY:         c = '{blue: 8'd45,  green: 8'd82,  red: 8'd160};
            SOIL_BTEXTURAL:    c = '{blue: 8'd63,  green: 8'd133, red: 8'd205};
            SOIL_ROCK:         c = '{blue: 8'd80,  green: 8'd80,  red: 8'd80};
            SOIL_NONE:         c = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
            SOIL_OTHER:        c = '{blue: 8'd100, green: 8'd100, red: 8'd100};
        endcase
        return c;
    endfunction

endpackage

[rtl/hillshade_soil_pixel_color_core.sv]
// Top level of the hillshade soil pixel color core: registers, handshake and datapath.
// A result passes through the input register and then the result register to the master side.
// Throughput: one item per cycle while m_tready is high; the input register refills whenever the result
// register moves on, so the shading logic between them sets the clock rate.
// Reset: aresetn is synchronous and active low; it empties both stages and sets
// water_level to 0. The configuration channel is always ready.
module hillshade_soil_pixel_color_core import hss_pkg::*; #(
    parameter int HEIGHT_WIDTH = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: water_level write.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [LEVEL_WIDTH-1:0]       cfg_data,     // water_level
    // Cell items.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // soil_class, cell_height, left_height, upper_height, zero fill
    input  logic [((CLASS_WIDTH + 3 * HEIGHT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // Pixel items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [PIXEL_WIDTH-1:0]       m_tdata       // pixel_word
);

    localparam int CELL_LSB  = CLASS_WIDTH;
    localparam int LEFT_LSB  = CLASS_WIDTH + HEIGHT_WIDTH;
    localparam int UPPER_LSB = CLASS_WIDTH + 2 * HEIGHT_WIDTH;

    logic                           in_valid_reg;
    logic [CLASS_WIDTH-1:0]         in_class_reg;
    logic signed [HEIGHT_WIDTH-1:0] in_cell_reg;
    logic signed [HEIGHT_WIDTH-1:0] in_left_reg;
    logic signed [HEIGHT_WIDTH-1:0] in_upper_reg;
    logic signed [LEVEL_WIDTH-1:0]  water_level_reg;
    logic                           res_valid_reg;
    logic [PIXEL_WIDTH-1:0]         res_data_reg;

    logic                           res_load;
    logic                           in_load;
    hss_shade_ctrl_t                shade_ctrl;
    logic [PIXEL_WIDTH-1:0]         pixel_next;

    // Stage enables: the result register frees when empty or taken.
    assign res_load  = !res_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || res_load;
    assign in_load   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = res_valid_reg;
    assign m_tdata   = res_data_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            water_level_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            water_level_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_class_reg <= s_tdata[CLASS_WIDTH-1:0];
            in_cell_reg  <= s_tdata[CELL_LSB +: HEIGHT_WIDTH];
            in_left_reg  <= s_tdata[LEFT_LSB +: HEIGHT_WIDTH];
            in_upper_reg <= s_tdata[UPPER_LSB +: HEIGHT_WIDTH];
        end
    end

    // Shading datapath between the two registers.
    hss_light #(
        .HEIGHT_WIDTH (HEIGHT_WIDTH)
    ) u_light (
        .cell_height  (in_cell_reg),
        .left_height  (in_left_reg),
        .upper_height (in_upper_reg),
        .water_level  (water_level_reg),
        .ctrl         (shade_ctrl)
    );

    hss_shade u_shade (
        .soil_class (in_class_reg),
        .ctrl       (shade_ctrl),
        .pixel_word (pixel_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_load) begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load && in_valid_reg) begin
            res_data_reg <= pixel_next;
        end
    end

`ifndef SYNTH
    // A new result only appears after the input stage held an item.
    a_res_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(in_valid_reg))
        else $error("result appeared without a held input item");

    // Every delivered pixel is opaque.
    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PIXEL_WIDTH-1 -: CHAN_WIDTH] == ALPHA_OPAQUE))
        else $error("pixel alpha is not opaque");

    // With both stages full and the output stalled, no item may enter.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // A stalled full input stage keeps its item for the next cycle.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !res_load) |=> (in_valid_reg && $stable(in_cell_reg)))
        else $error("input stage item lost during stall");
`endif

endmodule

[rtl/hss_light.sv]
// Terrain stage: slope-based light factor and the below-water test for one cell.
module hss_light import hss_pkg::*; #(
    parameter int HEIGHT_WIDTH = 20
) (
    input  logic signed [HEIGHT_WIDTH-1:0] cell_height,
    input  logic signed [HEIGHT_WIDTH-1:0] left_height,
    input  logic signed [HEIGHT_WIDTH-1:0] upper_height,
    input  logic signed [LEVEL_WIDTH-1:0]  water_level,
    output hss_shade_ctrl_t                ctrl
);

    localparam int DIFF_WIDTH = HEIGHT_WIDTH + 2;
    localparam int RAW_WIDTH  = HEIGHT_WIDTH + 4;
    localparam int CMP_WIDTH  = (HEIGHT_WIDTH > LEVEL_WIDTH) ? HEIGHT_WIDTH : LEVEL_WIDTH;

    localparam logic signed [RAW_WIDTH-1:0] RAW_BIAS = RAW_WIDTH'(LIGHT_BIAS_Q9);
    localparam logic signed [RAW_WIDTH-1:0] RAW_MIN  = RAW_WIDTH'(2 * LIGHT_MIN_Q8);
    localparam logic signed [RAW_WIDTH-1:0] RAW_MAX  = RAW_WIDTH'(2 * LIGHT_MAX_Q8);

    logic signed [DIFF_WIDTH-1:0] cell_x;
    logic signed [DIFF_WIDTH-1:0] left_x;
    logic signed [DIFF_WIDTH-1:0] upper_x;
    logic signed [DIFF_WIDTH-1:0] slope;
    logic signed [RAW_WIDTH-1:0]  slope_x;
    logic signed [RAW_WIDTH-1:0]  raw_light;
    logic signed [CMP_WIDTH-1:0]  cell_cmp;
    logic signed [CMP_WIDTH-1:0]  level_cmp;
    logic [LIGHT_WIDTH-1:0]       light_q8;
    logic                         below;

    // Slope term: twice the cell height minus both neighbors, exact.
    always_comb begin
        cell_x  = DIFF_WIDTH'(cell_height);
        left_x  = DIFF_WIDTH'(left_height);
        upper_x = DIFF_WIDTH'(upper_height);
        slope   = (cell_x <<< 1) - left_x - upper_x;
        slope_x = RAW_WIDTH'(slope);
        // 0.5 + 1.5 * slope, carried with 9 fraction bits.
        raw_light = RAW_BIAS + (slope_x <<< 1) + slope_x;
    end

    // Clamp to the light range and drop to 8 fraction bits.
    always_comb begin
        priority if (raw_light < RAW_MIN) begin
            light_q8 = LIGHT_WIDTH'(LIGHT_MIN_Q8);
        end else if (raw_light >= RAW_MAX) begin
            light_q8 = LIGHT_WIDTH'(LIGHT_MAX_Q8);
        end else begin
            light_q8 = raw_light[LIGHT_WIDTH:1];
        end
    end

    // Water test on sign-extended heights.
    always_comb begin
        cell_cmp  = CMP_WIDTH'(cell_height);
        level_cmp = CMP_WIDTH'(water_level);
        below     = cell_cmp < level_cmp;
    end

    assign ctrl = '{under: below, light: light_q8};

endmodule

[rtl/hss_shade.sv]
// Color stage: palette lookup, water tint, light scaling and RGBA packing.
module hss_shade import hss_pkg::*; (
    input  logic [CLASS_WIDTH-1:0] soil_class,
    input  hss_shade_ctrl_t        ctrl,
    output logic [PIXEL_WIDTH-1:0] pixel_word
);

    localparam int PROD_WIDTH = CHAN_WIDTH + LIGHT_WIDTH;

    rgb_t base;
    rgb_t tinted;
    rgb_t lit;

    // Scale one channel by the Q8 light factor, truncate and saturate.
    function automatic logic [CHAN_WIDTH-1:0] scale_chan(
        input logic [CHAN_WIDTH-1:0]  c,
        input logic [LIGHT_WIDTH-1:0] light
    );
        logic [PROD_WIDTH-1:0] prod;
        logic [CHAN_WIDTH:0]   v;
        prod = PROD_WIDTH'(c) * PROD_WIDTH'(light);
        v    = prod[PROD_WIDTH-1:CHAN_WIDTH];
        return v[CHAN_WIDTH] ? {CHAN_WIDTH{1'b1}} : v[CHAN_WIDTH-1:0];
    endfunction

    // Average of a channel with the water channel, rounded down.
    function automatic logic [CHAN_WIDTH-1:0] blend_chan(
        input logic [CHAN_WIDTH-1:0] c,
        input logic [CHAN_WIDTH-1:0] w
    );
        logic [CHAN_WIDTH:0] sum;
        sum = {1'b0, c} + {1'b0, w};
        return sum[CHAN_WIDTH:1];
    endfunction

    // Base color, optionally tinted toward water blue.
    always_comb begin
        base = soil_color(soil_class);
        if (ctrl.under) begin
            tinted.red   = blend_chan(base.red,   WATER_RGB.red);
            tinted.green = blend_chan(base.green, WATER_RGB.green);
            tinted.blue  = blend_chan(base.blue,  WATER_RGB.blue);
        end else begin
            tinted = base;
        end
    end

    // Hillshade each channel and pack with an opaque alpha.
    always_comb begin
        lit.red    = scale_chan(tinted.red,   ctrl.light);
        lit.green  = scale_chan(tinted.green, ctrl.light);
        lit.blue   = scale_chan(tinted.blue,  ctrl.light);
        pixel_word = {ALPHA_OPAQUE, lit};
    end

endmodule
